>>> sv/whtf_pkg.sv
// ============================================================================
// whtf_pkg
// Shared types and constants of the Walsh-Hadamard transform filter.
// ============================================================================
`default_nettype none

package whtf_pkg;

    // Largest transform length exponent and saturated sample width
    localparam int MAX_LOG2_LENGTH = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int VALUE_W    = 27;
    localparam int ACC_W      = 37;
    localparam int MAG_W      = 26;
    localparam int ENERGY_W   = 51;
    localparam int DC_W       = 16;
    localparam int LG_W       = 4;
    localparam int MODE_W     = 2;
    localparam int RATIO_W    = 16;
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_W      = MAG_W + RATIO_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE            = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_RATIO = 2'd2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INVERSE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } whtf_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [INDEX_W-1:0]        result_index;
        logic [ENERGY_W-1:0]       energy;
        logic signed [DC_W-1:0]    dc_component;
        logic                      last_result;
    } whtf_out_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_EMIT
    } whtf_kind_t;

    // One classified transaction, passed from front to back
    typedef struct packed {
        whtf_kind_t                kind;
        logic                      store;
        logic [LG_W-1:0]           lg;
        logic [MODE_W-1:0]         md;
        logic signed [VALUE_W-1:0] value;
    } whtf_cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PAD,
        B_BF,
        B_STAT,
        B_LIM,
        B_THR,
        B_SHIFT,
        B_RD,
        B_OUT
    } whtf_back_state_t;

endpackage

`default_nettype wire

>>> sv/whtf_ram.sv
// ============================================================================
// whtf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module whtf_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/whtf_queue.sv
// ============================================================================
// whtf_queue
// Small register FIFO that decouples the front from the back.
// ============================================================================
`default_nettype none

module whtf_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> sv/whtf_front.sv
// ============================================================================
// whtf_front
// Accepts input transactions and classifies them as load, start or emit.
// ============================================================================
`default_nettype none

module whtf_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_fire,
    input  wire whtf_pkg::whtf_in_t                    item,
    input  wire logic [whtf_pkg::LG_W-1:0]             log2_length,
    input  wire logic [whtf_pkg::MODE_W-1:0]           mode,
    output logic                                       cmd_push,
    output whtf_pkg::whtf_cmd_t                        cmd,
    output logic [whtf_pkg::MAX_LOG2_LENGTH-1:0]       cmd_addr
);

    import whtf_pkg::*;

    localparam int AW        = MAX_LOG2_LENGTH;
    localparam int SAT_HI_I  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [VALUE_W-1:0] SAT_HI = VALUE_W'(SAT_HI_I);
    localparam logic signed [VALUE_W-1:0] SAT_LO = VALUE_W'(-SAT_HI_I - 1);
    localparam logic [LG_W-1:0] MAX_LG = LG_W'(MAX_LOG2_LENGTH);

    logic [AW:0]               load_cnt_reg, load_cnt_next;
    logic                      emitting_reg, emitting_next;
    logic [AW-1:0]             emit_pos_reg, emit_pos_next;
    logic [AW:0]               n_held_reg, n_held_next;

    logic [LG_W-1:0]           lg_eff;
    logic [MODE_W-1:0]         md_eff;
    logic [AW:0]               n_cur;
    logic signed [VALUE_W-1:0] sat_value;

    // Clamp length, fold unused mode into forward, saturate the sample
    always_comb
    begin
        if (log2_length == '0)
        begin
            lg_eff = LG_W'(1);
        end
        else if (log2_length > MAX_LG)
        begin
            lg_eff = MAX_LG;
        end
        else
        begin
            lg_eff = log2_length;
        end
        md_eff = (mode == MODE_INVERSE || mode == MODE_THRESHOLD) ? mode : MODE_FORWARD;
        n_cur  = {{AW{1'b0}}, 1'b1} << lg_eff;
        if (item.value > SAT_HI)
        begin
            sat_value = SAT_HI;
        end
        else if (item.value < SAT_LO)
        begin
            sat_value = SAT_LO;
        end
        else
        begin
            sat_value = item.value;
        end
    end

    // Classify the transaction and track load and emit positions
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        emitting_next = emitting_reg;
        emit_pos_next = emit_pos_reg;
        n_held_next   = n_held_reg;
        cmd_push      = 1'b0;
        cmd.kind      = CMD_LOAD;
        cmd.store     = 1'b0;
        cmd.lg        = lg_eff;
        cmd.md        = md_eff;
        cmd.value     = (md_eff == MODE_INVERSE) ? item.value : sat_value;
        cmd_addr      = load_cnt_reg[AW-1:0];
        if (item_fire)
        begin
            if (!emitting_reg)
            begin
                cmd.store = (load_cnt_reg < n_cur);
                if (cmd.store)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                end
                if (item.last_value)
                begin
                    cmd.kind      = CMD_START;
                    cmd_push      = 1'b1;
                    emitting_next = 1'b1;
                    emit_pos_next = AW'(1);
                    n_held_next   = n_cur;
                end
                else
                begin
                    cmd_push = cmd.store;
                end
            end
            else
            begin
                cmd.kind = CMD_EMIT;
                cmd_addr = emit_pos_reg;
                cmd_push = 1'b1;
                if ({1'b0, emit_pos_reg} == n_held_reg - 1'b1)
                begin
                    emitting_next = 1'b0;
                    load_cnt_next = '0;
                    emit_pos_next = '0;
                end
                else
                begin
                    emit_pos_next = emit_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            emitting_reg <= 1'b0;
            emit_pos_reg <= '0;
            n_held_reg   <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            emitting_reg <= emitting_next;
            emit_pos_reg <= emit_pos_next;
            n_held_reg   <= n_held_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/whtf_back.sv
// ============================================================================
// whtf_back
// Executes classified transactions: work memory writes, the butterfly
// passes, statistics, thresholding, scaling and result output.
// ============================================================================
`default_nettype none

module whtf_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire whtf_pkg::whtf_cmd_t                 q_cmd,
    input  wire logic [whtf_pkg::MAX_LOG2_LENGTH-1:0] q_addr,
    output logic                                     q_pop,
    input  wire logic [whtf_pkg::RATIO_W-1:0]        threshold_ratio,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output whtf_pkg::whtf_out_t                      result
);

    import whtf_pkg::*;

    localparam int AW = MAX_LOG2_LENGTH;

    whtf_back_state_t        state_reg, state_next;
    logic [LG_W-1:0]         lg_reg, lg_next;
    logic [MODE_W-1:0]       md_reg, md_next;
    logic [AW:0]             n_reg, n_next;
    logic [AW:0]             ptr_reg, ptr_next;
    logic                    v1_reg, v1_next;
    logic                    v2_reg, v2_next;
    logic                    v3_reg, v3_next;
    logic                    first1_reg, first1_next;
    logic [AW-1:0]           widx_reg, widx_next;
    logic [LG_W-1:0]         st_reg, st_next;
    logic [AW-1:0]           k_reg, k_next;
    logic [1:0]              sub_reg, sub_next;
    logic                    bf2_reg, bf2_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ENERGY_W-1:0]     energy_reg, energy_next;
    logic [MAG_W-1:0]        largest_reg, largest_next;
    logic signed [DC_W-1:0]  dc_reg, dc_next;

    // Payload registers
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [ENERGY_W-1:0]     sq_reg, sq_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic signed [ACC_W-1:0] a_reg, a_next;
    logic signed [ACC_W-1:0] d_reg, d_next;
    whtf_out_t               out_reg, out_next;

    // Memory port
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [ACC_W-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic signed [ACC_W-1:0] rdata;

    logic [AW-1:0]           bf_mask;
    logic [AW-1:0]           bf_a;
    logic [AW-1:0]           bf_b;
    logic [ACC_W-1:0]        abs_v;
    logic [MAG_W-1:0]        mag_w;
    logic signed [ACC_W-1:0] shr_v;
    logic [2*MAG_W-1:0]      sq_full;
    logic                    out_free;
    logic [AW:0]             n_cmd;

    whtf_ram #(
        .WIDTH (ACC_W),
        .DEPTH (1 << AW)
    ) u_work_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Butterfly pair addresses, magnitude, scaling and square
    always_comb
    begin
        bf_mask = (AW'(1) << st_reg) - 1'b1;
        bf_a    = ((k_reg & ~bf_mask) << 1) | (k_reg & bf_mask);
        bf_b    = bf_a | (AW'(1) << st_reg);
        abs_v   = rdata[ACC_W-1] ? ACC_W'(-rdata) : rdata;
        mag_w   = abs_v[MAG_W-1:0];
        shr_v   = rdata >>> lg_reg;
        sq_full = mag_reg * mag_reg;
        out_free = !out_valid_reg || result_ready;
        n_cmd   = {{AW{1'b0}}, 1'b1} << q_cmd.lg;
    end

    // Sequence the back end
    always_comb
    begin
        state_next     = state_reg;
        lg_next        = lg_reg;
        md_next        = md_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        v3_next        = v3_reg;
        first1_next    = first1_reg;
        widx_next      = widx_reg;
        st_next        = st_reg;
        k_next         = k_reg;
        sub_next       = sub_reg;
        bf2_next       = bf2_reg;
        pos_next       = pos_reg;
        energy_next    = energy_reg;
        largest_next   = largest_reg;
        dc_next        = dc_reg;
        mag_next       = mag_reg;
        sq_next        = sq_reg;
        lim_next       = lim_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        re             = 1'b0;
        raddr          = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            we    = q_cmd.store;
                            waddr = q_addr;
                            wdata = {{(ACC_W-VALUE_W){q_cmd.value[VALUE_W-1]}}, q_cmd.value};
                        end
                        CMD_START:
                        begin
                            we           = q_cmd.store;
                            waddr        = q_addr;
                            wdata        = {{(ACC_W-VALUE_W){q_cmd.value[VALUE_W-1]}},
                                            q_cmd.value};
                            lg_next      = q_cmd.lg;
                            md_next      = q_cmd.md;
                            n_next       = n_cmd;
                            ptr_next     = q_cmd.store ? {1'b0, q_addr} + 1'b1 : n_cmd;
                            energy_next  = '0;
                            largest_next = '0;
                            dc_next      = '0;
                            state_next   = B_PAD;
                        end
                        CMD_EMIT:
                        begin
                            re         = 1'b1;
                            raddr      = q_addr;
                            pos_next   = q_addr;
                            state_next = B_OUT;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end

            B_PAD:
            begin
                // Zero-fill the tail of a short block
                if (ptr_reg < n_reg)
                begin
                    we       = 1'b1;
                    waddr    = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    st_next    = '0;
                    k_next     = '0;
                    sub_next   = '0;
                    bf2_next   = 1'b0;
                    state_next = B_BF;
                end
            end

            B_BF:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        re       = 1'b1;
                        raddr    = bf_a;
                        sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        re       = 1'b1;
                        raddr    = bf_b;
                        a_next   = rdata;
                        sub_next = 2'd2;
                    end
                    2'd2:
                    begin
                        we       = 1'b1;
                        waddr    = bf_a;
                        wdata    = a_reg + rdata;
                        d_next   = a_reg - rdata;
                        sub_next = 2'd3;
                    end
                    default:
                    begin
                        we       = 1'b1;
                        waddr    = bf_b;
                        wdata    = d_reg;
                        sub_next = 2'd0;
                        if ({1'b0, k_reg} == (n_reg >> 1) - 1'b1)
                        begin
                            k_next = '0;
                            if (st_reg == lg_reg - 1'b1)
                            begin
                                ptr_next = '0;
                                v1_next  = 1'b0;
                                v2_next  = 1'b0;
                                v3_next  = 1'b0;
                                if (!bf2_reg && md_reg != MODE_INVERSE)
                                begin
                                    state_next = B_STAT;
                                end
                                else
                                begin
                                    state_next = B_SHIFT;
                                end
                            end
                            else
                            begin
                                st_next = st_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                endcase
            end

            B_STAT:
            begin
                // Issue reads, then magnitude, square and accumulate
                v1_next = 1'b0;
                if (ptr_reg < n_reg)
                begin
                    re          = 1'b1;
                    raddr       = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                    v1_next     = 1'b1;
                    first1_next = (ptr_reg == '0);
                end
                v2_next = v1_reg;
                if (v1_reg)
                begin
                    mag_next = mag_w;
                    if (first1_reg)
                    begin
                        dc_next = shr_v[DC_W-1:0];
                    end
                end
                v3_next = v2_reg;
                if (v2_reg)
                begin
                    sq_next = sq_full[ENERGY_W-1:0];
                    if (mag_reg > largest_reg)
                    begin
                        largest_next = mag_reg;
                    end
                end
                if (v3_reg)
                begin
                    energy_next = energy_reg + sq_reg;
                end
                if (ptr_reg == n_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    if (md_reg == MODE_THRESHOLD)
                    begin
                        state_next = B_LIM;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = B_RD;
                    end
                end
            end

            B_LIM:
            begin
                lim_next   = largest_reg * threshold_ratio;
                ptr_next   = '0;
                v1_next    = 1'b0;
                state_next = B_THR;
            end

            B_THR:
            begin
                // Drop coefficients below the limit
                v1_next = 1'b0;
                if (ptr_reg < n_reg)
                begin
                    re        = 1'b1;
                    raddr     = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                    v1_next   = 1'b1;
                    widx_next = ptr_reg[AW-1:0];
                end
                if (v1_reg && ({mag_w, {RATIO_W{1'b0}}} < lim_reg))
                begin
                    we    = 1'b1;
                    waddr = widx_reg;
                end
                if (ptr_reg == n_reg && !v1_reg)
                begin
                    st_next    = '0;
                    k_next     = '0;
                    sub_next   = '0;
                    bf2_next   = 1'b1;
                    state_next = B_BF;
                end
            end

            B_SHIFT:
            begin
                // Scale by 1/N with a floor shift
                v1_next = 1'b0;
                if (ptr_reg < n_reg)
                begin
                    re        = 1'b1;
                    raddr     = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                    v1_next   = 1'b1;
                    widx_next = ptr_reg[AW-1:0];
                end
                if (v1_reg)
                begin
                    we    = 1'b1;
                    waddr = widx_reg;
                    wdata = shr_v;
                end
                if (ptr_reg == n_reg && !v1_reg)
                begin
                    pos_next   = '0;
                    state_next = B_RD;
                end
            end

            B_RD:
            begin
                re         = 1'b1;
                raddr      = pos_reg;
                state_next = B_OUT;
            end

            B_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_next.result_value = rdata[VALUE_W-1:0];
                    out_next.result_index = INDEX_W'(pos_reg);
                    out_next.energy       = energy_reg;
                    out_next.dc_component = dc_reg;
                    out_next.last_result  = ({1'b0, pos_reg} == n_reg - 1'b1);
                    out_valid_next        = 1'b1;
                    state_next            = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            lg_reg        <= LG_W'(1);
            md_reg        <= MODE_FORWARD;
            n_reg         <= '0;
            ptr_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            widx_reg      <= '0;
            st_reg        <= '0;
            k_reg         <= '0;
            sub_reg       <= '0;
            bf2_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            largest_reg   <= '0;
            dc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lg_reg        <= lg_next;
            md_reg        <= md_next;
            n_reg         <= n_next;
            ptr_reg       <= ptr_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            first1_reg    <= first1_next;
            widx_reg      <= widx_next;
            st_reg        <= st_next;
            k_reg         <= k_next;
            sub_reg       <= sub_next;
            bf2_reg       <= bf2_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            energy_reg    <= energy_next;
            largest_reg   <= largest_next;
            dc_reg        <= dc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sq_reg  <= sq_next;
        lim_reg <= lim_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

>>> sv/walsh_hadamard_transform_filter.sv
// ============================================================================
// walsh_hadamard_transform_filter
// Block Walsh-Hadamard transform with forward, scaled inverse and
// threshold-filter modes over a shared in-place butterfly.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      whtf_in_t
//  result    out        result_valid / result_ready  whtf_out_t
//  cfg       in         cfg_write (no wait)          cfg_index, cfg_data
//
//  Loads write the work memory. The last value starts the block: zero fill
//  of the unloaded tail, butterflies that each read two values and write back
//  their sum and difference (two passes in threshold mode), statistics (not in
//  inverse mode), thresholding (threshold mode only) and scaling (not forward).
//  Each result is then read from the work memory into the output register.
//  Reset clears all control state; the work memory is not cleared.
//  A four-entry queue lets inputs be taken while results wait for the sink.
// ============================================================================
`default_nettype none

module walsh_hadamard_transform_filter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire whtf_pkg::whtf_in_t               item,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output whtf_pkg::whtf_out_t                   result,
    input  wire logic                             cfg_write,
    input  wire logic [whtf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [whtf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import whtf_pkg::*;

    localparam int AW  = MAX_LOG2_LENGTH;
    localparam int QW  = $bits(whtf_cmd_t) + AW;

    logic [LG_W-1:0]    log2_length_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic               item_fire;
    logic               f_push;
    whtf_cmd_t          f_cmd;
    logic [AW-1:0]      f_addr;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [QW-1:0]      q_rdata;
    whtf_cmd_t          q_cmd;
    logic [AW-1:0]      q_addr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_length_reg <= LG_W'(8);
            mode_reg        <= MODE_FORWARD;
            ratio_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LOG2_LENGTH:     log2_length_reg <= cfg_data[LG_W-1:0];
                CFG_MODE:            mode_reg        <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD_RATIO: ratio_reg       <= cfg_data[RATIO_W-1:0];
                default:             ratio_reg       <= ratio_reg;
            endcase
        end
    end

    assign item_ready = !q_full;
    assign item_fire  = item_valid && item_ready;

    whtf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_fire   (item_fire),
        .item        (item),
        .log2_length (log2_length_reg),
        .mode        (mode_reg),
        .cmd_push    (f_push),
        .cmd         (f_cmd),
        .cmd_addr    (f_addr)
    );

    whtf_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_cmd, f_addr}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign {q_cmd, q_addr} = q_rdata;

    whtf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_addr          (q_addr),
        .q_pop           (q_pop),
        .threshold_ratio (ratio_reg),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

endmodule

`default_nettype wire

>>> tb/walsh_hadamard_transform_filter_tb.sv
// ----------------------------------------------------------------------------
// walsh_hadamard_transform_filter_tb
// Self-checking regression for the block Walsh-Hadamard transform filter.
// A scoreboard class mirrors the block's load, transform, threshold and emit
// behavior and checks every result transaction in order. Stimulus is a short
// directed set of corner cases followed by random blocks over many register
// settings, with bursty input traffic and a stalling result sink.
// ----------------------------------------------------------------------------
`default_nettype none

module walsh_hadamard_transform_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import whtf_pkg::*;

    localparam int MAX_LG      = MAX_LOG2_LENGTH;
    localparam int DEPTH       = 1 << MAX_LG;
    localparam int SAMPLE_HI   = 32767;
    localparam int SAMPLE_LO   = -32768;
    localparam int LOAD_TARGET = 1800;
    localparam int DRAIN_WAIT  = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    // ------------------------------------------------------------------------
    // Transform predictor and store of expected results
    // ------------------------------------------------------------------------
    class whtf_scoreboard;
        int unsigned  reg_lg    = 8;
        int unsigned  reg_mode  = 0;
        int unsigned  reg_ratio = 0;
        longint       work_mem [DEPTH];
        int unsigned  load_cnt  = 0;
        longint unsigned energy_acc = 0;
        longint unsigned peak_mag   = 0;
        bit           emitting  = 0;
        int unsigned  held_lg   = 1;
        int unsigned  held_md   = 0;
        longint       dc_val    = 0;
        int unsigned  emit_idx  = 0;
        whtf_out_t    expected_results [$];
        int           errors    = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_LOG2_LENGTH:     reg_lg    = d[LG_W-1:0];
                CFG_MODE:            reg_mode  = d[MODE_W-1:0];
                CFG_THRESHOLD_RATIO: reg_ratio = d[RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_lg();
            if (reg_lg < 1) return 1;
            if (reg_lg > MAX_LG) return MAX_LG;
            return reg_lg;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function void hadamard(int unsigned n);
            longint a;
            longint b;
            for (int unsigned s = 1; s < n; s = s << 1)
                for (int unsigned i = 0; i < n; i += 2 * s)
                    for (int unsigned j = 0; j < s; j++)
                    begin
                        a = work_mem[i + j];
                        b = work_mem[i + j + s];
                        work_mem[i + j]     = a + b;
                        work_mem[i + j + s] = a - b;
                    end
        endfunction

        function void compute(int unsigned lg, int unsigned md);
            int unsigned n;
            longint unsigned m;
            longint unsigned lim;
            n = 1 << lg;
            // Pad a short block with zeros
            for (int unsigned i = (load_cnt < n) ? load_cnt : n; i < n; i++)
                work_mem[i] = 0;
            hadamard(n);
            energy_acc = 0;
            peak_mag   = 0;
            dc_val     = 0;
            if (md != MODE_INVERSE)
            begin
                for (int unsigned i = 0; i < n; i++)
                begin
                    m = magnitude(work_mem[i]);
                    energy_acc += m * m;
                    if (m > peak_mag) peak_mag = m;
                end
                dc_val = work_mem[0] >>> lg;
            end
            // Drop small coefficients, then transform back
            if (md == MODE_THRESHOLD)
            begin
                lim = peak_mag * longint'(reg_ratio);
                for (int unsigned i = 0; i < n; i++)
                    if (magnitude(work_mem[i]) * 65536 < lim) work_mem[i] = 0;
                hadamard(n);
            end
            if (md != MODE_FORWARD)
                for (int unsigned i = 0; i < n; i++)
                    work_mem[i] = work_mem[i] >>> lg;
            held_lg = lg;
            held_md = md;
        endfunction

        function void note_item(whtf_in_t it);
            int unsigned lg;
            int unsigned md;
            int unsigned n;
            longint v;
            whtf_out_t r;
            if (!emitting)
            begin
                lg = eff_lg();
                md = (reg_mode == 3) ? MODE_FORWARD : reg_mode;
                v  = it.value;
                n  = 1 << lg;
                if (load_cnt < n)
                begin
                    if (md != MODE_INVERSE)
                        v = (v > SAMPLE_HI) ? SAMPLE_HI : ((v < SAMPLE_LO) ? SAMPLE_LO : v);
                    work_mem[load_cnt] = v;
                    load_cnt++;
                end
                if (!it.last_value) return;
                compute(lg, md);
                emitting = 1;
                emit_idx = 0;
            end
            n = 1 << held_lg;
            r.result_value = VALUE_W'(work_mem[emit_idx]);
            r.result_index = INDEX_W'(emit_idx);
            r.energy       = ENERGY_W'(energy_acc);
            r.dc_component = DC_W'(dc_val);
            r.last_result  = (emit_idx + 1 >= n);
            expected_results.push_back(r);
            emit_idx++;
            if (emit_idx >= n)
            begin
                emitting = 0;
                load_cnt = 0;
                emit_idx = 0;
            end
        endfunction

        function void check_result(whtf_out_t got);
            whtf_out_t e;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction, index %0d", got.result_index);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.result_value !== e.result_value)
            begin
                $error("result_value: expected %0d, actual %0d", e.result_value, got.result_value);
                errors++;
            end
            if (got.result_index !== e.result_index)
            begin
                $error("result_index: expected %0d, actual %0d", e.result_index, got.result_index);
                errors++;
            end
            if (got.energy !== e.energy)
            begin
                $error("energy: expected %0d, actual %0d", e.energy, got.energy);
                errors++;
            end
            if (got.dc_component !== e.dc_component)
            begin
                $error("dc_component: expected %0d, actual %0d", e.dc_component, got.dc_component);
                errors++;
            end
            if (got.last_result !== e.last_result)
            begin
                $error("last_result: expected %0d, actual %0d", e.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block instance
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    whtf_in_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    whtf_out_t result;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    whtf_scoreboard sb = new();
    longint cycles = 0;
    int burst_left = 0;
    int loads_sent = 0;
    int big_blocks = 0;

    always #5 clk = ~clk;

    walsh_hadamard_transform_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("walsh_hadamard_transform_filter regression: fail");
            $finish;
        end
    end

    // Stall the result sink in stretches of differing pressure
    int sink_mode = 0;
    int sink_left = 0;
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = $urandom_range(0, 2);
            sink_left = $urandom_range(20, 300);
        end
        sink_left--;
        case (sink_mode)
            0:       result_ready = 1'b1;
            1:       result_ready = $urandom_range(0, 1);
            default: result_ready = ($urandom_range(0, 3) == 0);
        endcase
    end

    // Capture each result transaction at the edge, check it at the next fall
    always @(posedge clk)
    begin
        whtf_out_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got = result;
            @(negedge clk);
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    task automatic send_item(logic signed [VALUE_W-1:0] v, logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        item_valid = 1'b1;
        item.value = v;
        item.last_value = last;
        // Hold until the transaction is taken
        forever
        begin
            @(posedge clk);
            if (item_ready) break;
        end
        sb.note_item(item);
        loads_sent++;
    endtask

    task automatic cfg_set(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        item_valid = 1'b0;
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return VALUE_W'($urandom());
            1: return VALUE_W'($signed($urandom_range(0, 200)) - 100);
            2: return VALUE_W'($signed($urandom_range(0, 65535)) - 32768);
            default:
                case ($urandom_range(0, 5))
                    0: return {1'b0, {(VALUE_W-1){1'b1}}};
                    1: return {1'b1, {(VALUE_W-1){1'b0}}};
                    2: return VALUE_W'(SAMPLE_HI);
                    3: return VALUE_W'(SAMPLE_LO);
                    4: return VALUE_W'(SAMPLE_HI + 1);
                    default: return VALUE_W'(SAMPLE_LO - 1);
                endcase
        endcase
    endfunction

    // Feed items that only advance emission; some carry a stray last flag
    task automatic send_drain(int k);
        for (int i = 0; i < k; i++)
            send_item(rand_value(), $urandom_range(0, 4) == 0);
    endtask

    // Load one block of random content, then pull all of its results
    task automatic send_block();
        int n;
        int count;
        n = 1 << sb.eff_lg();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: count = n;
            5, 6, 7:       count = $urandom_range(1, n);
            default:       count = n + $urandom_range(1, 3);
        endcase
        for (int i = 0; i < count - 1; i++)
            send_item(rand_value(), 1'b0);
        send_item(rand_value(), 1'b1);
        send_drain(n - 1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int lg;
        int r;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, saturation, padding, overflow, ignored last
        cfg_set(CFG_LOG2_LENGTH, 1);
        cfg_set(CFG_MODE, MODE_FORWARD);
        cfg_set(CFG_THRESHOLD_RATIO, 0);
        send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
        send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
        send_item(3, 1'b1);
        send_item(5, 1'b1);
        send_item(9, 1'b0);
        send_item(100, 1'b0);
        send_item(-100, 1'b0);
        send_item(7, 1'b0);
        send_item(9, 1'b1);
        send_drain(1);
        wait_idle();
        cfg_set(CFG_MODE, MODE_INVERSE);
        send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
        send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
        send_drain(1);
        wait_idle();
        cfg_set(CFG_LOG2_LENGTH, 2);
        cfg_set(CFG_MODE, MODE_THRESHOLD);
        cfg_set(CFG_THRESHOLD_RATIO, 16'hFFFF);
        send_item(1000, 1'b0);
        send_item(-3, 1'b0);
        send_item(40000, 1'b0);
        send_item(-40000, 1'b1);
        send_drain(3);
        wait_idle();
        cfg_set(CFG_LOG2_LENGTH, 0);
        cfg_set(CFG_MODE, 3);
        send_item(VALUE_W'(SAMPLE_HI), 1'b0);
        send_item(VALUE_W'(SAMPLE_LO), 1'b1);
        send_drain(1);

        // Random phases over many register settings
        while (loads_sent < LOAD_TARGET)
        begin
            wait_idle();
            // Leave a partly loaded block across a register change now and then
            if ($urandom_range(0, 6) == 0)
            begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    send_item(rand_value(), 1'b0);
                wait_idle();
            end
            r = $urandom_range(0, 99);
            if (r < 70)      lg = $urandom_range(1, 4);
            else if (r < 88) lg = $urandom_range(5, 6);
            else if (r < 94) lg = 0;
            else             lg = $urandom_range(10, 15);
            // Allow one full-length block, early enough to keep the item count
            if (lg >= 10)
            begin
                if (big_blocks >= 1 || loads_sent > LOAD_TARGET / 4) lg = $urandom_range(1, 3);
                else big_blocks++;
            end
            cfg_set(CFG_LOG2_LENGTH, CFG_DATA_W'(lg));
            cfg_set(CFG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0:       cfg_set(CFG_THRESHOLD_RATIO, 0);
                1:       cfg_set(CFG_THRESHOLD_RATIO, 16'hFFFF);
                default: cfg_set(CFG_THRESHOLD_RATIO, CFG_DATA_W'($urandom_range(0, 65535)));
            endcase
            for (int b = (lg >= 10) ? 1 : $urandom_range(1, 4); b > 0; b--)
                send_block();
        end

        // Drain and report
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("walsh_hadamard_transform_filter regression: pass");
        else
            $display("walsh_hadamard_transform_filter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
